>>> src/srdf_pkg.sv
package srdf_pkg;

  localparam int NumRegs   = 3;
  localparam int IdxW      = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int DecLimit  = 99999;
  localparam int OctBits   = 15;

  localparam logic signed [17:0] DecMax = 18'sd99999;
  localparam logic signed [17:0] DecMin = -18'sd99999;

  localparam logic [3:0] DigitBlank = 4'hF;

  typedef enum logic [1:0] {
    SIGN_PLUS  = 2'd0,
    SIGN_MINUS = 2'd1,
    SIGN_BLANK = 2'd2
  } sign_e;

  typedef struct packed {
    sign_e      sign;
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } codes_t;

  localparam codes_t BlankCodes = '{
    sign: SIGN_BLANK, d4: DigitBlank, d3: DigitBlank,
    d2: DigitBlank, d1: DigitBlank, d0: DigitBlank
  };

  // pre-split item held in the input register
  typedef struct packed {
    logic [1:0]         idx;
    logic               octal;
    logic               neg;
    logic               dec_ok;
    logic               oct_ok;
    logic [9:0]         hund;     // magnitude / 100
    logic [6:0]         rem;      // magnitude % 100
    logic [OctBits-1:0] oct_bits;
  } item_t;

  typedef struct packed {
    logic   idx_ok;
    logic   ok;
    codes_t codes;
  } fmt_t;

  // exact m / 100 for m < 100000: (m / 4) / 25 by reciprocal
  function automatic logic [9:0] div100(input logic [16:0] m);
    logic [27:0] prod;
    prod = 28'(m[16:2]) * 28'd5243;
    return prod[26:17];
  endfunction

  // exact q / 100 for q < 1000
  function automatic logic [3:0] div100_small(input logic [9:0] q);
    logic [13:0] prod;
    prod = 14'(q[9:2]) * 14'd41;
    return prod[13:10];
  endfunction

  // tens digit of x < 100
  function automatic logic [3:0] div10_small(input logic [6:0] x);
    logic [14:0] prod;
    prod = 15'(x) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

>>> src/signed_register_display_formatter_core.sv
// Signed display register formatter. Each stream transaction carries a value
// (tdata) plus a register index and radix flag (tuser). Decimal values within
// +/-99999 become a sign code and five digit codes, leading zeros blanked unless
// the leading_zero_enable register (APB address 0, bit 0) is set; octal values
// 0..32767 become a blank sign and five octal digits. Accepted codes update the
// chosen display register; the result reports accepted, changed and the codes.
// One transaction per cycle is sustained unless m_axis_tready stalls. The input
// register holds the value already split at /100; digit extraction, store compare
// and store write happen in the single stage ahead of the result register, so
// consecutive transactions to one register see each other's update.
module signed_register_display_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // value[17:0], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // register_index[1:0], radix_octal[2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sign_code[1:0], digit_4[5:2], digit_3[9:6], digit_2[13:10],
  // digit_1[17:14], digit_0[21:18], zero pad
  output logic [23:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // accepted[0], changed[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srdf_pkg::*;

  localparam logic RegLzEn = 1'b0;

  logic            lz_q;
  logic            cfg_wr;
  logic            in_vld;
  item_t           item;
  fmt_t            fmt;
  logic            out_ready;
  logic            adv;
  logic            acc, chg;
  codes_t          codes;
  logic            m_vld_q, m_vld_d;
  logic            m_acc_q, m_chg_q;
  codes_t          m_codes_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegLzEn) ? {31'd0, lz_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lz_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == RegLzEn)) begin
      lz_q <= pwdata[0];
    end
  end

  assign out_ready = !m_vld_q || m_axis_tready_i;
  assign adv       = in_vld && out_ready;

  srdf_in u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .adv_i           (out_ready),
    .vld_o           (in_vld),
    .item_o          (item)
  );

  srdf_fmt u_fmt (
    .item_i (item),
    .lz_i   (lz_q),
    .fmt_o  (fmt)
  );

  srdf_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .idx_i      (item.idx),
    .fmt_i      (fmt),
    .accepted_o (acc),
    .changed_o  (chg),
    .codes_o    (codes)
  );

  assign m_vld_d = adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_acc_q   <= acc;
      m_chg_q   <= chg;
      m_codes_q <= codes;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = {m_chg_q, m_acc_q};
  assign m_axis_tdata_o  = {2'b00, m_codes_q.d0, m_codes_q.d1, m_codes_q.d2,
                            m_codes_q.d3, m_codes_q.d4, m_codes_q.sign};

  a_chg_needs_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && m_chg_q |-> m_acc_q)
    else $error("changed reported without acceptance");

  a_octal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && m_acc_q && (m_codes_q.sign == SIGN_BLANK) |->
      (m_codes_q.d4 != DigitBlank) && (m_codes_q.d0 != DigitBlank))
    else $error("octal result with blanked digit");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_vld_q && (m_acc_q == $past(fmt.ok)))
    else $error("result register missed a transaction");

endmodule

>>> src/srdf_in.sv
module srdf_in (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [23:0]          s_axis_tdata_i,  // value[17:0], zero pad
  input  logic [2:0]           s_axis_tuser_i,  // register_index[1:0], radix_octal[2]
  input  logic                 adv_i,
  output logic                 vld_o,
  output srdf_pkg::item_t      item_o
);
  import srdf_pkg::*;

  logic                vld_q, vld_d;
  item_t               item_q, item_d;
  logic signed [17:0]  value;
  logic [17:0]         mag;
  logic                take;

  assign value = $signed(s_axis_tdata_i[17:0]);
  assign take  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !vld_q || adv_i;

  always_comb begin
    // magnitude of an out-of-range value is never used
    mag = value[17] ? 18'(-value) : 18'(value);
    item_d          = item_q;
    item_d.idx      = s_axis_tuser_i[1:0];
    item_d.octal    = s_axis_tuser_i[2];
    item_d.neg      = value[17];
    item_d.dec_ok   = (value >= DecMin) && (value <= DecMax);
    item_d.oct_ok   = (value[17:OctBits] == '0);
    item_d.hund     = div100(mag[16:0]);
    item_d.rem      = 7'(mag[16:0] - 17'(item_d.hund) * 17'd100);
    item_d.oct_bits = value[OctBits-1:0];
  end

  assign vld_d = take ? 1'b1 : (adv_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

>>> src/srdf_fmt.sv
module srdf_fmt (
  input  srdf_pkg::item_t item_i,
  input  logic            lz_i,
  output srdf_pkg::fmt_t  fmt_o
);
  import srdf_pkg::*;

  logic [3:0] d4, d3, d2, d1, d0;
  logic [6:0] mid;
  logic       z4, z3, z2, z1, z0;
  logic       blank_en;
  codes_t     dec_codes, oct_codes;

  always_comb begin
    d4  = div100_small(item_i.hund);
    mid = 7'(item_i.hund - 10'(d4) * 10'd100);
    d3  = div10_small(mid);
    d2  = 4'(mid - 7'(d3) * 7'd10);
    d1  = div10_small(item_i.rem);
    d0  = 4'(item_i.rem - 7'(d1) * 7'd10);
  end

  // leading-zero run from the top digit down
  assign z4 = (d4 == 4'd0);
  assign z3 = z4 && (d3 == 4'd0);
  assign z2 = z3 && (d2 == 4'd0);
  assign z1 = z2 && (d1 == 4'd0);
  assign z0 = z1 && (d0 == 4'd0);
  assign blank_en = !lz_i;

  always_comb begin
    dec_codes.sign = item_i.neg ? SIGN_MINUS : SIGN_PLUS;
    dec_codes.d4   = (blank_en && z4) ? DigitBlank : d4;
    dec_codes.d3   = (blank_en && z3) ? DigitBlank : d3;
    dec_codes.d2   = (blank_en && z2) ? DigitBlank : d2;
    dec_codes.d1   = (blank_en && z1) ? DigitBlank : d1;
    dec_codes.d0   = (blank_en && z0) ? DigitBlank : d0;

    oct_codes.sign = SIGN_BLANK;
    oct_codes.d4   = {1'b0, item_i.oct_bits[14:12]};
    oct_codes.d3   = {1'b0, item_i.oct_bits[11:9]};
    oct_codes.d2   = {1'b0, item_i.oct_bits[8:6]};
    oct_codes.d1   = {1'b0, item_i.oct_bits[5:3]};
    oct_codes.d0   = {1'b0, item_i.oct_bits[2:0]};
  end

  always_comb begin
    fmt_o.idx_ok = (32'(item_i.idx) < NumRegs);
    fmt_o.ok     = fmt_o.idx_ok && (item_i.octal ? item_i.oct_ok : item_i.dec_ok);
    fmt_o.codes  = item_i.octal ? oct_codes : dec_codes;
  end

endmodule

>>> src/srdf_store.sv
module srdf_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [1:0]       idx_i,
  input  srdf_pkg::fmt_t   fmt_i,
  output logic             accepted_o,
  output logic             changed_o,
  output srdf_pkg::codes_t codes_o
);
  import srdf_pkg::*;

  codes_t            regs_q [NumRegs];
  codes_t            stored;
  logic [IdxW-1:0]   idx;
  logic              wr_en;

  assign idx    = idx_i[IdxW-1:0];
  assign stored = fmt_i.idx_ok ? regs_q[idx] : BlankCodes;

  assign accepted_o = fmt_i.ok;
  assign changed_o  = fmt_i.ok && (fmt_i.codes != stored);
  assign codes_o    = fmt_i.ok ? fmt_i.codes : stored;
  assign wr_en      = adv_i && changed_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= BlankCodes;
      end
    end else if (wr_en) begin
      regs_q[idx] <= fmt_i.codes;
    end
  end

  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> regs_q[$past(idx)] == $past(fmt_i.codes))
    else $error("display register write not retained");

endmodule
